[hw/rtl/ubsd_pkg.sv]
// Types, constants and helper functions shared by the UTF-8 byte stream decoder.
`timescale 1ns / 1ps
`default_nettype none

package ubsd_pkg;

  localparam int unsigned JobDepth = 2;
  localparam int unsigned JobPtrW  = $clog2(JobDepth);
  localparam int unsigned JobCntW  = JobPtrW + 1;

  localparam logic [7:0]  Mask2Lead  = 8'hE0;
  localparam logic [7:0]  Form2Lead  = 8'hC0;
  localparam logic [7:0]  Mask3Lead  = 8'hF0;
  localparam logic [7:0]  Form3Lead  = 8'hE0;
  localparam logic [7:0]  Mask4Lead  = 8'hF8;
  localparam logic [7:0]  Form4Lead  = 8'hF0;
  localparam logic [7:0]  Pay2Mask   = 8'h1F;
  localparam logic [7:0]  Pay3Mask   = 8'h0F;
  localparam logic [7:0]  Pay4Mask   = 8'h07;
  localparam logic [7:0]  ContMask   = 8'h3F;
  localparam logic [20:0] QuestionCp = 21'h00003F;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       text_end;
  } in_word_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic        run_last;
    logic        text_done;
  } out_word_t;

  // A complete buffer to decode: up to four bytes, index of the last one, end flag.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic            text_end;
  } job_t;

  // Sequence length minus one implied by a first byte; zero for ASCII or invalid.
  function automatic logic [1:0] seq_len_m1(input logic [7:0] b);
    logic [1:0] len_m1;
    len_m1 = 2'd0;
    if ((b & Mask2Lead) == Form2Lead) begin
      len_m1 = 2'd1;
    end else if ((b & Mask3Lead) == Form3Lead) begin
      len_m1 = 2'd2;
    end else if ((b & Mask4Lead) == Form4Lead) begin
      len_m1 = 2'd3;
    end
    return len_m1;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/ubsd_front.sv]
// Front end: accepts bytes, collects multi-byte sequences and issues decode jobs.
`timescale 1ns / 1ps
`default_nettype none

module ubsd_front import ubsd_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     accept_i,
  input  wire in_word_t in_word_i,
  output logic          job_push_o,
  output job_t          job_o
);

  logic [2:0][7:0] held_q;
  logic [1:0]      cnt_q, cnt_d;
  logic [3:0][7:0] bytes;
  logic [7:0]      lead;
  logic            hold;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      bytes[j] = held_q[j];
    end
    bytes[3]        = '0;
    bytes[cnt_q]    = in_word_i.byte_value;
    lead            = bytes[0];
    hold            = !in_word_i.text_end && (cnt_q < seq_len_m1(lead));
    job_push_o      = accept_i && !hold;
    job_o.bytes     = bytes;
    job_o.last_idx  = cnt_q;
    job_o.text_end  = in_word_i.text_end;
    cnt_d           = cnt_q;
    if (accept_i) begin
      cnt_d = hold ? cnt_q + 2'd1 : 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && hold) begin
      held_q[cnt_q] <= in_word_i.byte_value;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/ubsd_job_fifo.sv]
// Short queue of decode jobs between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none

module ubsd_job_fifo import ubsd_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t job_i,
  input  wire logic pop_i,
  output logic      full_o,
  output logic      empty_o,
  output job_t      head_o
);

  job_t               mem_q [JobDepth];
  logic [JobPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [JobCntW-1:0] count_q;

  assign full_o  = (count_q == JobCntW'(JobDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/ubsd_back.sv]
// Back end: walks a decode job and emits one code point per cycle into the output register while it is free or popped.
`timescale 1ns / 1ps
`default_nettype none

module ubsd_back import ubsd_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire job_t job_i,
  input  wire logic job_empty_i,
  output logic      job_pop_o,
  input  wire logic pop_i,
  output logic      empty_o,
  output out_word_t out_word_o
);

  logic [1:0] pos_q;
  logic [1:0] k_q;
  out_word_t  out_q;
  logic       out_valid_q;

  logic       advance;
  logic [7:0] b0, b1, b2, b3;
  logic [1:0] len_m1;
  logic [2:0] pos_w, last_w, step;
  logic [20:0] cp;
  logic       last;

  always_comb begin
    advance = !job_empty_i && (!out_valid_q || pop_i);
    b0      = job_i.bytes[pos_q];
    b1      = job_i.bytes[pos_q + 2'd1];
    b2      = job_i.bytes[pos_q + 2'd2];
    b3      = job_i.bytes[pos_q + 2'd3];
    len_m1  = seq_len_m1(b0);
    pos_w   = {1'b0, pos_q};
    last_w  = {1'b0, job_i.last_idx};
    cp      = QuestionCp;
    step    = 3'd1;
    if (!b0[7]) begin
      cp = {13'd0, b0};
    end else if (len_m1 == 2'd1 && pos_w + 3'd1 <= last_w) begin
      cp   = {10'd0, 5'(b0 & Pay2Mask), 6'(b1 & ContMask)};
      step = 3'd2;
    end else if (len_m1 == 2'd2 && pos_w + 3'd2 <= last_w) begin
      cp   = {5'd0, 4'(b0 & Pay3Mask), 6'(b1 & ContMask), 6'(b2 & ContMask)};
      step = 3'd3;
    end else if (len_m1 == 2'd3 && pos_w + 3'd3 <= last_w) begin
      cp   = {3'(b0 & Pay4Mask), 6'(b1 & ContMask), 6'(b2 & ContMask),
              6'(b3 & ContMask)};
      step = 3'd4;
    end
    last      = (pos_w + step > last_w) || (k_q == 2'd2);
    job_pop_o = advance && last;
  end

  assign empty_o    = !out_valid_q;
  assign out_word_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= 2'd0;
      k_q         <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
        if (last) begin
          pos_q <= 2'd0;
          k_q   <= 2'd0;
        end else begin
          pos_q <= 2'(pos_w + step);
          k_q   <= k_q + 2'd1;
        end
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q.code_point <= cp;
      out_q.run_last   <= last;
      out_q.text_done  <= last && job_i.text_end;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/utf8_byte_stream_decoder_unit.sv]
// Top level of the UTF-8 byte stream decoder.
// The decoder takes one text byte per cycle while full is low and gives code points
// through a queue-like result port. Bytes of a multi-byte sequence are collected in
// the front end without producing a result; a completed buffer becomes a decode job
// in a two-entry queue, and the back end emits one result per cycle from it while
// its output register is free or popped. A result is registered first as a job in
// the queue and then in the output register. A text that ends in the middle of a
// sequence yields up to three results from one byte; the job queue lets the next
// bytes be accepted meanwhile, and full rises only when both job entries are taken.
`timescale 1ns / 1ps
`default_nettype none

module utf8_byte_stream_decoder_unit import ubsd_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push,
  output logic           full,
  input  wire in_word_t  in_word_i,
  output logic           empty,
  input  wire logic      pop,
  output out_word_t      out_word_o
);

  logic job_push;
  logic job_pop;
  logic job_full;
  logic job_empty;
  job_t job_in;
  job_t job_head;

  assign full = job_full;

  ubsd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (push && !job_full),
    .in_word_i  (in_word_i),
    .job_push_o (job_push),
    .job_o      (job_in)
  );

  ubsd_job_fifo u_job_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .job_i   (job_in),
    .pop_i   (job_pop),
    .full_o  (job_full),
    .empty_o (job_empty),
    .head_o  (job_head)
  );

  ubsd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job_head),
    .job_empty_i (job_empty),
    .job_pop_o   (job_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_word_o  (out_word_o)
  );

  a_push_needs_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_push |-> (push && !job_full))
    else $error("Job issued without an accepted word.");

  a_pop_needs_job : assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop |-> !job_empty)
    else $error("Job retired from an empty queue.");

  a_done_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_word_o.text_done) |-> out_word_o.run_last)
    else $error("End of text flagged on a result that is not the last of its word.");

endmodule

`default_nettype wire
